// ===== rtl/cmr_pkg.sv =====
package cmr_pkg;

    // Operand widths of the shared serial units.
    localparam int MUL_B_W = 34;
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 34;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // 1000 * ln(1000) and ln(2), both scaled by 2^32.
    localparam logic [47:0] LN1000K = 48'd29668583012000;
    localparam logic [31:0] LN2Q32 = 32'd2977044472;

    localparam int TAYLOR_TERMS = 16;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WF,
        ST_DR,
        ST_X,
        ST_K,
        ST_TM,
        ST_TD,
        ST_TRIG,
        ST_C0,
        ST_C1,
        ST_IC,
        ST_IS,
        ST_PR,
        ST_PI,
        ST_GR,
        ST_GI,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_OUT
    } cmr_state_t;

    // Arctangent of 2^-i in Q0.32 turns.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/complex_modal_resonator.sv =====
// One beat is in flight at a time; the next input beat is taken as soon as the result is
// loaded into the output register, even if that result has not yet been taken.
// Reset (aresetn low, synchronous): state cleared to zero, sample rate back to 48000 Hz,
// output empty.
module complex_modal_resonator #(
    parameter int STATE_BITS      = 40,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Sample rate register write port.
    input  logic        cfg_wr_en,
    input  logic [17:0] cfg_wr_data,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: sample_in[15:0], freq_sixteenths_hz[35:16], decay_ms[51:36],
    // amp_gain[67:52], phase_turns[83:68], zero fill [87:84].
    input  logic [87:0] s_tdata,
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: sample_out[15:0].
    output logic [15:0] m_tdata
);

    // The whole computation is a sequencer that drives three shared serial
    // units: a shift-add multiplier, a restoring divider and a CORDIC
    // rotator.  The frequency angle needs one divide; the exponential decay
    // needs one multiply and two divides for the reduced exponent and
    // sixteen multiply/divide pairs for the Taylor series, which sets most
    // of the latency.
    localparam int SH      = 32 - TRIG_TABLE_BITS;
    localparam int MUL_A_W = (STATE_BITS > 36) ? STATE_BITS : 36;
    localparam int MUL_B_W = cmr_pkg::MUL_B_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int N_W     = cmr_pkg::DIV_N_W;
    localparam int D_W     = cmr_pkg::DIV_D_W;

    localparam logic [31:0] FRAC_MASK = (32'd1 << SH) - 32'd1;
    localparam logic signed [SUM_W-1:0] ST_MAX =
        {{(SUM_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [STATE_BITS-1:0] O_MAX = STATE_BITS'(32767);
    localparam logic signed [STATE_BITS-1:0] O_MIN = STATE_BITS'(-32768);

    cmr_pkg::cmr_state_t state_reg, state_next;

    logic [17:0]               rate_reg, rate_next;
    logic signed [15:0]        x_in_reg, x_in_next;
    logic [15:0]               dms_reg, dms_next;
    logic signed [15:0]        amp_reg, amp_next;
    logic [15:0]               ph_reg, ph_next;
    logic [31:0]               wf_reg, wf_next;
    logic [4:0]                k_reg, k_next;
    logic [31:0]               r_reg, r_next;
    logic signed [35:0]        sum_reg, sum_next;
    logic [4:0]                n_reg, n_next;
    logic signed [33:0]        d_reg, d_next;
    logic                      trig_sel_reg, trig_sel_next;
    logic signed [31:0]        c0_reg, c0_next;
    logic signed [31:0]        s0_reg, s0_next;
    logic signed [31:0]        s1_reg, s1_next;
    logic signed [MUL_B_W-1:0] cv_reg, cv_next;
    logic signed [MUL_B_W-1:0] sv_reg, sv_next;
    logic signed [MUL_B_W-1:0] cre_reg, cre_next;
    logic signed [MUL_B_W-1:0] cim_reg, cim_next;
    logic signed [MUL_A_W-1:0] gre_reg, gre_next;
    logic signed [MUL_A_W-1:0] gim_reg, gim_next;
    logic signed [PROD_W-1:0]  ein_reg, ein_next;
    logic signed [PROD_W-1:0]  psum_reg, psum_next;
    logic signed [STATE_BITS-1:0] nre_reg, nre_next;
    logic signed [STATE_BITS-1:0] real_acc_reg, real_acc_next;
    logic signed [STATE_BITS-1:0] imag_acc_reg, imag_acc_next;
    logic [15:0]               out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      mul_done;

    logic                      div_start;
    logic [N_W-1:0]            div_n;
    logic [D_W-1:0]            div_d;
    logic [N_W-1:0]            div_q;
    logic [D_W-1:0]            div_r;
    logic                      div_done;

    logic                      cor_start;
    logic [31:0]               cor_angle;
    logic signed [31:0]        cor_cos;
    logic signed [31:0]        cor_sin;
    logic                      cor_done;

    logic [31:0]               ang;
    logic [31:0]               a0;
    logic [31:0]               a1;
    logic signed [MUL_B_W-1:0] frac_b;
    logic signed [MUL_B_W-1:0] interp;
    logic signed [MUL_B_W-1:0] prod_q30;
    logic signed [MUL_A_W-1:0] prod_q12;
    logic signed [PROD_W-1:0]  prod_q21;
    logic signed [SUM_W-1:0]   mac_sum;
    logic signed [STATE_BITS-1:0] o_shift;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [STATE_BITS-1:0] r;
        if (v > ST_MAX) begin
            r = STATE_BITS'(ST_MAX);
        end else if (v < ST_MIN) begin
            r = STATE_BITS'(ST_MIN);
        end else begin
            r = STATE_BITS'(v);
        end
        return r;
    endfunction

    cmr_serial_mul #(
        .A_W (MUL_A_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    cmr_serial_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    cmr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .cos_out (cor_cos),
        .sin_out (cor_sin),
        .done    (cor_done)
    );

    always_comb begin
        // Table points either side of the current angle and the position between them.
        ang      = trig_sel_reg ? {ph_reg, 16'd0} : wf_reg;
        a0       = ang & ~FRAC_MASK;
        a1       = a0 + FRAC_MASK + 32'd1;
        frac_b   = $signed(MUL_B_W'(ang & FRAC_MASK));
        interp   = MUL_B_W'(mul_prod >>> SH);
        prod_q30 = MUL_B_W'(mul_prod >>> 30);
        prod_q12 = MUL_A_W'(mul_prod >>> 12);
        prod_q21 = mul_prod >>> 21;
        o_shift  = imag_acc_reg >>> 9;
        mac_sum  = '0;

        state_next     = state_reg;
        rate_next      = rate_reg;
        x_in_next      = x_in_reg;
        dms_next       = dms_reg;
        amp_next       = amp_reg;
        ph_next        = ph_reg;
        wf_next        = wf_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        trig_sel_next  = trig_sel_reg;
        c0_next        = c0_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        cv_next        = cv_reg;
        sv_next        = sv_reg;
        cre_next       = cre_reg;
        cim_next       = cim_reg;
        gre_next       = gre_reg;
        gim_next       = gim_reg;
        ein_next       = ein_reg;
        psum_next      = psum_reg;
        nre_next       = nre_reg;
        real_acc_next  = real_acc_reg;
        imag_acc_next  = imag_acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        cor_start = 1'b0;
        cor_angle = a0;

        s_tready = (state_reg == cmr_pkg::ST_IDLE);

        if (cfg_wr_en) begin
            rate_next = cfg_wr_data;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cmr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    x_in_next     = $signed(s_tdata[15:0]);
                    dms_next      = s_tdata[51:36];
                    amp_next      = $signed(s_tdata[67:52]);
                    ph_next       = s_tdata[83:68];
                    trig_sel_next = 1'b0;
                    if (rate_reg == 18'd0) begin
                        // No rate: no rotation and no pole.
                        wf_next    = '0;
                        d_next     = '0;
                        state_next = cmr_pkg::ST_TRIG;
                    end else begin
                        div_start  = 1'b1;
                        div_n      = {s_tdata[35:16], 28'd0};
                        div_d      = D_W'(rate_reg);
                        state_next = cmr_pkg::ST_WF;
                    end
                end
            end
            cmr_pkg::ST_WF: begin
                if (div_done) begin
                    wf_next = div_q[31:0];
                    if (dms_reg == 16'd0) begin
                        d_next     = '0;
                        state_next = cmr_pkg::ST_TRIG;
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = $signed(MUL_A_W'(rate_reg));
                        mul_b      = $signed(MUL_B_W'(dms_reg));
                        state_next = cmr_pkg::ST_DR;
                    end
                end
            end
            cmr_pkg::ST_DR: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_n      = cmr_pkg::LN1000K;
                    div_d      = mul_prod[D_W-1:0];
                    state_next = cmr_pkg::ST_X;
                end
            end
            cmr_pkg::ST_X: begin
                if (div_done) begin
                    // Split the exponent into whole octaves and a remainder below ln 2.
                    div_start  = 1'b1;
                    div_n      = div_q;
                    div_d      = D_W'(cmr_pkg::LN2Q32);
                    state_next = cmr_pkg::ST_K;
                end
            end
            cmr_pkg::ST_K: begin
                if (div_done) begin
                    if (div_q >= N_W'(31)) begin
                        d_next     = '0;
                        state_next = cmr_pkg::ST_TRIG;
                    end else begin
                        k_next     = div_q[4:0];
                        r_next     = div_r[31:0];
                        sum_next   = 36'sh1_0000_0000;
                        n_next     = 5'd1;
                        mul_start  = 1'b1;
                        mul_a      = $signed(MUL_A_W'(33'h1_0000_0000));
                        mul_b      = $signed(MUL_B_W'(div_r[31:0]));
                        state_next = cmr_pkg::ST_TM;
                    end
                end
            end
            cmr_pkg::ST_TM: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_n      = {16'd0, mul_prod[63:32]};
                    div_d      = D_W'(n_reg);
                    state_next = cmr_pkg::ST_TD;
                end
            end
            cmr_pkg::ST_TD: begin
                if (div_done) begin
                    // Odd terms of the series for e^-r are subtracted.
                    if (n_reg[0]) begin
                        sum_next = sum_reg - $signed(36'(div_q[32:0]));
                    end else begin
                        sum_next = sum_reg + $signed(36'(div_q[32:0]));
                    end
                    if (n_reg == 5'(cmr_pkg::TAYLOR_TERMS)) begin
                        d_next     = 34'((sum_next >>> 2) >>> k_reg);
                        state_next = cmr_pkg::ST_TRIG;
                    end else begin
                        n_next     = n_reg + 5'd1;
                        mul_start  = 1'b1;
                        mul_a      = $signed(MUL_A_W'(div_q[32:0]));
                        mul_b      = $signed(MUL_B_W'(r_reg));
                        state_next = cmr_pkg::ST_TM;
                    end
                end
            end
            cmr_pkg::ST_TRIG: begin
                cor_start  = 1'b1;
                cor_angle  = a0;
                state_next = cmr_pkg::ST_C0;
            end
            cmr_pkg::ST_C0: begin
                if (cor_done) begin
                    c0_next    = cor_cos;
                    s0_next    = cor_sin;
                    cor_start  = 1'b1;
                    cor_angle  = a1;
                    state_next = cmr_pkg::ST_C1;
                end
            end
            cmr_pkg::ST_C1: begin
                if (cor_done) begin
                    s1_next    = cor_sin;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(cor_cos) - MUL_A_W'(c0_reg);
                    mul_b      = frac_b;
                    state_next = cmr_pkg::ST_IC;
                end
            end
            cmr_pkg::ST_IC: begin
                if (mul_done) begin
                    cv_next    = MUL_B_W'(c0_reg) + interp;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(s1_reg) - MUL_A_W'(s0_reg);
                    mul_b      = frac_b;
                    state_next = cmr_pkg::ST_IS;
                end
            end
            cmr_pkg::ST_IS: begin
                if (mul_done) begin
                    sv_next   = MUL_B_W'(s0_reg) + interp;
                    mul_start = 1'b1;
                    mul_b     = cv_reg;
                    if (!trig_sel_reg) begin
                        mul_a      = MUL_A_W'(d_reg);
                        state_next = cmr_pkg::ST_PR;
                    end else begin
                        mul_a      = MUL_A_W'(amp_reg);
                        state_next = cmr_pkg::ST_GR;
                    end
                end
            end
            cmr_pkg::ST_PR: begin
                if (mul_done) begin
                    cre_next   = prod_q30;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(d_reg);
                    mul_b      = sv_reg;
                    state_next = cmr_pkg::ST_PI;
                end
            end
            cmr_pkg::ST_PI: begin
                if (mul_done) begin
                    cim_next      = prod_q30;
                    trig_sel_next = 1'b1;
                    state_next    = cmr_pkg::ST_TRIG;
                end
            end
            cmr_pkg::ST_GR: begin
                if (mul_done) begin
                    gre_next   = prod_q12;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(amp_reg);
                    mul_b      = sv_reg;
                    state_next = cmr_pkg::ST_GI;
                end
            end
            cmr_pkg::ST_GI: begin
                if (mul_done) begin
                    gim_next   = prod_q12;
                    mul_start  = 1'b1;
                    mul_a      = gre_reg;
                    mul_b      = MUL_B_W'(x_in_reg);
                    state_next = cmr_pkg::ST_M1;
                end
            end
            cmr_pkg::ST_M1: begin
                if (mul_done) begin
                    ein_next   = prod_q21;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(real_acc_reg);
                    mul_b      = cre_reg;
                    state_next = cmr_pkg::ST_M2;
                end
            end
            cmr_pkg::ST_M2: begin
                if (mul_done) begin
                    psum_next  = mul_prod;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(imag_acc_reg);
                    mul_b      = cim_reg;
                    state_next = cmr_pkg::ST_M3;
                end
            end
            cmr_pkg::ST_M3: begin
                if (mul_done) begin
                    // Both pole products are summed exactly before the single floor.
                    mac_sum    = ((SUM_W'(psum_reg) - SUM_W'(mul_prod)) >>> 30)
                                 + SUM_W'(ein_reg);
                    nre_next   = sat_state(mac_sum);
                    mul_start  = 1'b1;
                    mul_a      = gim_reg;
                    mul_b      = MUL_B_W'(x_in_reg);
                    state_next = cmr_pkg::ST_M4;
                end
            end
            cmr_pkg::ST_M4: begin
                if (mul_done) begin
                    ein_next   = prod_q21;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(real_acc_reg);
                    mul_b      = cim_reg;
                    state_next = cmr_pkg::ST_M5;
                end
            end
            cmr_pkg::ST_M5: begin
                if (mul_done) begin
                    psum_next  = mul_prod;
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(imag_acc_reg);
                    mul_b      = cre_reg;
                    state_next = cmr_pkg::ST_M6;
                end
            end
            cmr_pkg::ST_M6: begin
                if (mul_done) begin
                    mac_sum       = ((SUM_W'(psum_reg) + SUM_W'(mul_prod)) >>> 30)
                                    + SUM_W'(ein_reg);
                    imag_acc_next = sat_state(mac_sum);
                    real_acc_next = nre_reg;
                    state_next    = cmr_pkg::ST_OUT;
                end
            end
            cmr_pkg::ST_OUT: begin
                // Wait only while the previous result still sits unread.
                if (!out_valid_reg || m_tready) begin
                    if (o_shift > O_MAX) begin
                        out_next = 16'h7FFF;
                    end else if (o_shift < O_MIN) begin
                        out_next = 16'h8000;
                    end else begin
                        out_next = o_shift[15:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = cmr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cmr_pkg::ST_IDLE;
            rate_reg      <= 18'd48000;
            real_acc_reg  <= '0;
            imag_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
            trig_sel_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            real_acc_reg  <= real_acc_next;
            imag_acc_reg  <= imag_acc_next;
            out_valid_reg <= out_valid_next;
            trig_sel_reg  <= trig_sel_next;
        end
        x_in_reg <= x_in_next;
        dms_reg  <= dms_next;
        amp_reg  <= amp_next;
        ph_reg   <= ph_next;
        wf_reg   <= wf_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        c0_reg   <= c0_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        cv_reg   <= cv_next;
        sv_reg   <= sv_next;
        cre_reg  <= cre_next;
        cim_reg  <= cim_next;
        gre_reg  <= gre_next;
        gim_reg  <= gim_next;
        ein_reg  <= ein_next;
        psum_reg <= psum_next;
        nre_reg  <= nre_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/cmr_serial_mul.sv =====
// Signed shift-add multiplier: one multiplier bit per cycle.
module cmr_serial_mul #(
    parameter int A_W = 40
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [A_W-1:0]                  a,
    input  logic signed [cmr_pkg::MUL_B_W-1:0]     b,
    output logic signed [A_W+cmr_pkg::MUL_B_W-1:0] prod,
    output logic                                   done
);

    localparam int B_W = cmr_pkg::MUL_B_W;
    localparam int CNT_W = $clog2(B_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [A_W-1:0] a_reg, a_next;
    logic signed [A_W:0] hi_reg, hi_next;
    logic [B_W-1:0]      lo_reg, lo_next;

    logic signed [A_W+1:0] a_ext;
    logic signed [A_W+1:0] addend;
    logic signed [A_W+1:0] sum;
    logic                  last;

    always_comb begin
        last   = (cnt_reg == CNT_W'(B_W - 1));
        a_ext  = (A_W + 2)'(a_reg);
        // The top bit of a two's complement multiplier has negative weight.
        if (lo_reg[0]) begin
            addend = last ? -a_ext : a_ext;
        end else begin
            addend = '0;
        end
        sum = (A_W + 2)'(hi_reg) + addend;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end else if (busy_reg) begin
            hi_next  = sum[A_W+1:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign prod = {hi_reg[A_W-1:0], lo_reg};
    assign done = done_reg;

endmodule

// ===== rtl/cmr_serial_div.sv =====
// Unsigned restoring divider: one quotient bit per cycle.
module cmr_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cmr_pkg::DIV_N_W-1:0]   dividend,
    input  logic [cmr_pkg::DIV_D_W-1:0]   divisor,
    output logic [cmr_pkg::DIV_N_W-1:0]   quotient,
    output logic [cmr_pkg::DIV_D_W-1:0]   remainder,
    output logic                          done
);

    localparam int N_W = cmr_pkg::DIV_N_W;
    localparam int D_W = cmr_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   q_reg, q_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;

    logic [D_W:0] trial;
    logic         fits;

    always_comb begin
        trial = {rem_reg, q_reg[N_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? D_W'(trial - {1'b0, dvs_reg}) : D_W'(trial);
            q_next   = {q_reg[N_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== rtl/cmr_cordic.sv =====
// Rotation CORDIC, one micro-rotation per cycle, with quadrant mapping.
module cmr_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out,
    output logic               done
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         i_reg, i_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;

    logic signed [33:0] dx, dy;
    logic signed [32:0] at;
    logic signed [33:0] c_raw, s_raw;

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(cmr_pkg::ONE_Q30)) begin
            r = cmr_pkg::ONE_Q30;
        end else if (v < -34'(cmr_pkg::ONE_Q30)) begin
            r = -cmr_pkg::ONE_Q30;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    always_comb begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = $signed({1'b0, cmr_pkg::atan_turn(i_reg)});

        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            i_next    = '0;
            quad_next = angle[31:30];
            x_next    = cmr_pkg::CORDIC_K;
            y_next    = '0;
            z_next    = $signed({3'b000, angle[29:0]});
        end else if (busy_reg) begin
            if (!z_reg[32]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(cmr_pkg::CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        unique case (quad_reg)
            2'd0: begin
                c_raw = x_reg;
                s_raw = y_reg;
            end
            2'd1: begin
                c_raw = -y_reg;
                s_raw = x_reg;
            end
            2'd2: begin
                c_raw = -x_reg;
                s_raw = -y_reg;
            end
            default: begin
                c_raw = y_reg;
                s_raw = -x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign cos_out = clamp_unit(c_raw);
    assign sin_out = clamp_unit(s_raw);
    assign done    = done_reg;

endmodule

// ===== rtl/cmr_checker.sv =====
module cmr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // A waiting result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

    // One beat at a time: the input side closes right after a beat is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second input beat taken while busy");

    // A result cannot appear the cycle after an input beat is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result beat appeared too early");

endmodule

bind complex_modal_resonator cmr_checker u_cmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_complex_modal_resonator.sv =====
`timescale 1ns / 1ps

module tb_complex_modal_resonator;

    localparam int STATE_W = 40;
    localparam int TABLE_W = 10;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2500;
    localparam int MAX_REPORTS = 10;

    // One input beat worth of mode parameters.
    typedef struct packed {
        logic [15:0]        phase;
        logic signed [15:0] amp;
        logic [15:0]        decay;
        logic [19:0]        freq;
        logic signed [15:0] smp;
    } mode_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [17:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    complex_modal_resonator uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // The 8 ns clock toggles every half period.
    always #4 aclk = ~aclk;

    // Beats waiting to be sent, and the output samples the resonator should produce.
    mode_beat_t         send_q[$];
    logic signed [15:0] want_q[$];

    // The predictor keeps its own copy of the sample rate and the complex state.
    logic [17:0]  rate_hz;
    longint       re_state;
    longint       im_state;

    int  mismatches;
    int  stall_cycles;
    bit  calm;          // When set, the bench never stalls either side of the bus.
    bit  s_taken;       // The beat on the bus was taken at the last rising edge.

    // Rotates the start vector through a CORDIC of fixed length and then moves the
    // result into the quadrant of the angle. Both outputs are Q2.30, clamped to one.
    function automatic void cordic_point(input logic [31:0] ang, output longint c,
                                         output longint s);
        longint x, y, z, dx, dy;
        x = cmr_pkg::CORDIC_K;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < cmr_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(cmr_pkg::atan_turn(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(cmr_pkg::atan_turn(i[4:0]));
            end
        end
        case (ang[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        if (c > cmr_pkg::ONE_Q30) c = cmr_pkg::ONE_Q30;
        if (c < -cmr_pkg::ONE_Q30) c = -cmr_pkg::ONE_Q30;
        if (s > cmr_pkg::ONE_Q30) s = cmr_pkg::ONE_Q30;
        if (s < -cmr_pkg::ONE_Q30) s = -cmr_pkg::ONE_Q30;
    endfunction

    // Table lookup with linear interpolation on the low angle bits.
    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        logic [31:0] a0, a1;
        longint frac, c0, s0, c1, s1;
        a0 = {ang[31:32-TABLE_W], {(32-TABLE_W){1'b0}}};
        a1 = a0 + (32'd1 << (32 - TABLE_W));
        frac = longint'(ang[31-TABLE_W:0]);
        cordic_point(a0, c0, s0);
        cordic_point(a1, c1, s1);
        c = c0 + (((c1 - c0) * frac) >>> (32 - TABLE_W));
        s = s0 + (((s1 - s0) * frac) >>> (32 - TABLE_W));
    endfunction

    // Pole radius in Q2.30: exp(-ln(1000) / (decay seconds * rate)).
    function automatic longint pole_radius(input logic [15:0] dms, input logic [17:0] rate);
        longint unsigned x, k, r, term;
        longint sum;
        if (dms == 0 || rate == 0) return 0;
        x = longint'(cmr_pkg::LN1000K) / (longint'(dms) * longint'(rate));
        k = x / longint'(cmr_pkg::LN2Q32);
        if (k >= 31) return 0;
        r = x - k * longint'(cmr_pkg::LN2Q32);
        term = 64'd1 << 32;
        sum = 64'sd1 << 32;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * r) >> 32) / n;
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return (sum >>> 2) >>> k;
    endfunction

    // One complex multiply-accumulate lane, split into high and low state halves so
    // nothing overflows 64 bits, then saturated to the state width.
    function automatic longint mac_lane(input longint g, input longint x, input longint c1,
                                        input longint s1, input longint c2, input longint s2);
        longint h1, h2, l1, l2, e, hp, rem, lim;
        h1 = s1 >>> 32;
        h2 = s2 >>> 32;
        l1 = s1 & 64'hFFFF_FFFF;
        l2 = s2 & 64'hFFFF_FFFF;
        e = ((c1 * l1 + c2 * l2) >>> 30) + ((g * x) >>> 21);
        hp = c1 * h1 + c2 * h2 + (e >>> 2);
        rem = e & 3;
        lim = 64'sd1 <<< (STATE_W - 3);
        if (hp >= lim) return (64'sd1 <<< (STATE_W - 1)) - 1;
        if (hp < -lim) return -(64'sd1 <<< (STATE_W - 1));
        return hp * 4 + rem;
    endfunction

    // Advances the resonator state by one sample and returns the output sample.
    function automatic logic signed [15:0] resonate(input mode_beat_t b);
        logic [31:0] w;
        longint d, cw, sw, cp, sp, pre, pim, gre, gim, nre, nim, o;
        w = (rate_hz == 0) ? 32'd0 : 32'((longint'(b.freq) << 28) / longint'(rate_hz));
        d = pole_radius(b.decay, rate_hz);
        sin_cos(w, cw, sw);
        pre = (d * cw) >>> 30;
        pim = (d * sw) >>> 30;
        sin_cos({b.phase, 16'd0}, cp, sp);
        gre = (longint'(b.amp) * cp) >>> 12;
        gim = (longint'(b.amp) * sp) >>> 12;
        nre = mac_lane(gre, longint'(b.smp), pre, re_state, -pim, im_state);
        nim = mac_lane(gim, longint'(b.smp), pim, re_state, pre, im_state);
        re_state = nre;
        im_state = nim;
        o = im_state >>> 9;
        if (o > 32767) o = 32767;
        if (o < -32768) o = -32768;
        return 16'(o);
    endfunction

    // Mostly musical settings so the resonance actually rings, with some fully random
    // beats mixed in so every input bit toggles.
    function automatic mode_beat_t random_beat(input bit short_decay);
        mode_beat_t b;
        b = mode_beat_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(99) < 70) begin
            b.freq = 20'($urandom_range(16 * 8000, 16 * 20));
            b.decay = short_decay ? 16'($urandom_range(3, 1))
                                  : 16'($urandom_range(3000, 20));
            b.amp = 16'sd4096 - 16'($urandom_range(8192));
            if ($urandom_range(3) != 0) b.smp = 16'sd0;
        end
        return b;
    endfunction

    // Driver: presents the next pending beat at the falling edge, holding it until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 32);
            if (s_tvalid && !s_taken) begin
                // The current beat has not been taken yet, so it stays on the bus.
            end else if (send_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'd0, send_q[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted input beat and checks each accepted result beat.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want_q.push_back(resonate(mode_beat_t'(s_tdata[83:0])));
                void'(send_q.pop_front());
            end
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat %0d", $signed(m_tdata));
                end else begin
                    if (m_tdata !== want_q[0]) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want_q[0], $signed(m_tdata));
                    end
                    void'(want_q.pop_front());
                end
            end
        end
    end

    // Watchdog: the run is stuck if no beat moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_complex_modal_resonator NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Writes the sample rate while the block is idle and mirrors it in the predictor.
    task automatic set_rate(input logic [17:0] hz);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        rate_hz = hz;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queues random beats and waits until every one has produced its result.
    task automatic run_phase(input int count, input bit short_decay);
        for (int i = 0; i < count; i++) send_q.push_back(random_beat(short_decay));
        wait (send_q.size() == 0 && want_q.size() == 0);
    endtask

    task automatic add_beat(input logic signed [15:0] smp, input logic [19:0] freq,
                            input logic [15:0] dcy, input logic signed [15:0] amp,
                            input logic [15:0] ph);
        mode_beat_t b;
        b.smp = smp; b.freq = freq; b.decay = dcy; b.amp = amp; b.phase = ph;
        send_q.push_back(b);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        calm = 1'b0;
        s_taken = 1'b0;
        rate_hz = 18'd48000;
        re_state = 0;
        im_state = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset sample rate: field extremes, zero decay, the
        // longest decay, and a frequency far above the rate so the angle wraps.
        add_beat(16'sh7FFF, 20'd16000, 16'd500, 16'sh7FFF, 16'd0);
        add_beat(-16'sh8000, 20'd16000, 16'd500, 16'sh7FFF, 16'd0);
        add_beat(16'sh7FFF, 20'd0, 16'd0, 16'sh1000, 16'hFFFF);
        add_beat(16'sh4000, 20'hFFFFF, 16'hFFFF, -16'sh8000, 16'h4000);
        add_beat(-16'sh8000, 20'hFFFFF, 16'hFFFF, -16'sh8000, 16'h8000);
        add_beat(16'sh7FFF, 20'd7040, 16'hFFFF, 16'sh7FFF, 16'hC000);
        add_beat(16'sh7FFF, 20'd7040, 16'hFFFF, 16'sh7FFF, 16'h2000);
        add_beat(16'sh7FFF, 20'd7040, 16'hFFFF, 16'sh7FFF, 16'h2000);
        add_beat(16'sh0000, 20'd7040, 16'hFFFF, 16'sh7FFF, 16'h0000);
        add_beat(16'sh0000, 20'd7040, 16'd1, 16'sh1000, 16'h0000);
        add_beat(16'sh0001, 20'd768000, 16'd100, 16'sh1000, 16'h1234);
        add_beat(16'shFFFF, 20'd384000, 16'd100, 16'shFFFF, 16'h0001);
        add_beat(16'sh0000, 20'd1, 16'd2000, 16'sh0001, 16'h7FFF);
        add_beat(16'sh2AAA, 20'h55555, 16'h5555, 16'sh2AAA, 16'hAAAA);
        add_beat(-16'sh2AAB, 20'hAAAAA, 16'hAAAA, -16'sh2AAB, 16'h5555);
        add_beat(16'sh0000, 20'd16000, 16'd0, 16'sh7FFF, 16'h0000);
        wait (send_q.size() == 0 && want_q.size() == 0);

        run_phase(300, 1'b0);
        set_rate(18'd8000);
        run_phase(250, 1'b0);
        // A stretch where the bench never stalls either side, at the widest rate value.
        calm = 1'b1;
        set_rate(18'h3FFFF);
        run_phase(150, 1'b0);
        calm = 1'b0;
        // Zero sample rate forces a zero pole and a zero frequency angle.
        set_rate(18'd0);
        run_phase(40, 1'b0);
        // A tiny rate with decays of a few milliseconds drives the pole to zero.
        set_rate(18'd100);
        run_phase(40, 1'b1);
        set_rate(18'd192000);
        run_phase(250, 1'b0);
        set_rate(18'd44100);
        run_phase(150, 1'b0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && want_q.size() == 0) begin
            $display("tb_complex_modal_resonator OK");
        end else begin
            $display("tb_complex_modal_resonator NOT OK");
        end
        $finish;
    end

endmodule
